>>> hdl/bst_pkg.sv
// Package for the byte stream tokenizer: token kinds, scan modes and the
// result and decode structures shared by the decoder and the top level.
// Depends on nothing.
package bst_pkg;

    localparam int unsigned KindW = 4;
    localparam int unsigned ByteW = 8;

    localparam logic [KindW-1:0] KIND_ID     = 4'd0;
    localparam logic [KindW-1:0] KIND_INT    = 4'd1;
    localparam logic [KindW-1:0] KIND_EQUALS = 4'd2;
    localparam logic [KindW-1:0] KIND_ARROW  = 4'd3;
    localparam logic [KindW-1:0] KIND_LPAREN = 4'd4;
    localparam logic [KindW-1:0] KIND_RPAREN = 4'd5;
    localparam logic [KindW-1:0] KIND_LBRACE = 4'd6;
    localparam logic [KindW-1:0] KIND_RBRACE = 4'd7;
    localparam logic [KindW-1:0] KIND_COLON  = 4'd8;
    localparam logic [KindW-1:0] KIND_COMMA  = 4'd9;
    localparam logic [KindW-1:0] KIND_LT     = 4'd10;
    localparam logic [KindW-1:0] KIND_GT     = 4'd11;
    localparam logic [KindW-1:0] KIND_SEMI   = 4'd12;
    localparam logic [KindW-1:0] KIND_EOF    = 4'd13;
    localparam logic [KindW-1:0] KIND_ERROR  = 4'd14;

    localparam logic [ByteW-1:0] CH_NUL    = 8'h00;
    localparam logic [ByteW-1:0] CH_TAB    = 8'h09;
    localparam logic [ByteW-1:0] CH_LF     = 8'h0A;
    localparam logic [ByteW-1:0] CH_SPACE  = 8'h20;
    localparam logic [ByteW-1:0] CH_LPAREN = 8'h28;
    localparam logic [ByteW-1:0] CH_RPAREN = 8'h29;
    localparam logic [ByteW-1:0] CH_COMMA  = 8'h2C;
    localparam logic [ByteW-1:0] CH_COLON  = 8'h3A;
    localparam logic [ByteW-1:0] CH_SEMI   = 8'h3B;
    localparam logic [ByteW-1:0] CH_LT     = 8'h3C;
    localparam logic [ByteW-1:0] CH_EQUALS = 8'h3D;
    localparam logic [ByteW-1:0] CH_GT     = 8'h3E;
    localparam logic [ByteW-1:0] CH_LBRACE = 8'h7B;
    localparam logic [ByteW-1:0] CH_RBRACE = 8'h7D;

    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_IDENT  = 5'b00010,
        MODE_NUMBER = 5'b00100,
        MODE_EQHELD = 5'b01000,
        MODE_HALT   = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [ByteW-1:0] value;
        logic             first_char;
        logic             token_end;
        logic             last;
    } result_t;

    // Results produced by one byte: count (0 to 2), the two slots and the next mode.
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
        mode_t      mode;
    } decode_t;

endpackage

>>> hdl/bst_decode.sv
// Per-byte decoder of the byte stream tokenizer: from the current scan mode
// and one source byte it forms up to two results and the next scan mode.
// Depends on bst_pkg.
module bst_decode
    import bst_pkg::*;
(
    input  logic [ByteW-1:0] ch,
    input  mode_t            mode,
    output decode_t          dec
);

    logic    is_letter;
    logic    is_digit;
    logic    idle_valid;
    result_t idle_res;
    mode_t   idle_mode;
    result_t res0;
    result_t res1;
    logic [1:0] count;

    assign is_letter = ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A));
    assign is_digit  = (ch >= 8'h30) && (ch <= 8'h39);

    // Handling of a byte with no token open.
    always_comb begin
        idle_valid = 1'b1;
        idle_mode  = MODE_IDLE;
        idle_res   = '{kind: KIND_ERROR, value: ch, first_char: 1'b1, token_end: 1'b1,
                       last: 1'b0};
        if (is_letter) begin
            idle_res.kind      = KIND_ID;
            idle_res.token_end = 1'b0;
            idle_mode          = MODE_IDENT;
        end else if (is_digit) begin
            idle_res.kind      = KIND_INT;
            idle_res.token_end = 1'b0;
            idle_mode          = MODE_NUMBER;
        end else begin
            case (ch)
                CH_EQUALS: begin
                    idle_valid = 1'b0;
                    idle_mode  = MODE_EQHELD;
                end
                CH_SPACE, CH_TAB, CH_LF: idle_valid = 1'b0;
                CH_NUL: begin
                    idle_res.kind  = KIND_EOF;
                    idle_res.value = '0;
                end
                CH_LPAREN: idle_res.kind = KIND_LPAREN;
                CH_RPAREN: idle_res.kind = KIND_RPAREN;
                CH_LBRACE: idle_res.kind = KIND_LBRACE;
                CH_RBRACE: idle_res.kind = KIND_RBRACE;
                CH_COLON:  idle_res.kind = KIND_COLON;
                CH_COMMA:  idle_res.kind = KIND_COMMA;
                CH_LT:     idle_res.kind = KIND_LT;
                CH_GT:     idle_res.kind = KIND_GT;
                CH_SEMI:   idle_res.kind = KIND_SEMI;
                default:   idle_mode = MODE_HALT;
            endcase
        end
    end

    always_comb begin
        res0  = idle_res;
        res1  = idle_res;
        count = {1'b0, idle_valid};
        dec.mode = idle_mode;
        case (mode)
            MODE_HALT: begin
                count    = 2'd0;
                dec.mode = MODE_HALT;
            end
            MODE_IDENT: begin
                if (is_letter) begin
                    res0     = '{kind: KIND_ID, value: ch, first_char: 1'b0, token_end: 1'b0,
                                 last: 1'b0};
                    count    = 2'd1;
                    dec.mode = MODE_IDENT;
                end else begin
                    res0  = '{kind: KIND_ID, value: '0, first_char: 1'b0, token_end: 1'b1,
                              last: 1'b0};
                    count = 2'd1 + {1'b0, idle_valid};
                end
            end
            MODE_NUMBER: begin
                if (is_digit) begin
                    res0     = '{kind: KIND_INT, value: ch, first_char: 1'b0, token_end: 1'b0,
                                 last: 1'b0};
                    count    = 2'd1;
                    dec.mode = MODE_NUMBER;
                end else begin
                    res0  = '{kind: KIND_INT, value: '0, first_char: 1'b0, token_end: 1'b1,
                              last: 1'b0};
                    count = 2'd1 + {1'b0, idle_valid};
                end
            end
            MODE_EQHELD: begin
                if (ch == CH_GT) begin
                    res0     = '{kind: KIND_ARROW, value: ch, first_char: 1'b1,
                                 token_end: 1'b1, last: 1'b0};
                    count    = 2'd1;
                    dec.mode = MODE_IDLE;
                end else begin
                    res0  = '{kind: KIND_EQUALS, value: CH_EQUALS, first_char: 1'b1,
                              token_end: 1'b1, last: 1'b0};
                    count = 2'd1 + {1'b0, idle_valid};
                end
            end
            default: ;
        endcase
        res0.last = (count == 2'd1);
        res1.last = (count == 2'd2);
        dec.count = count;
        dec.res0  = res0;
        dec.res1  = res1;
    end

endmodule

>>> hdl/byte_stream_tokenizer.sv
// Byte stream tokenizer: input stage register, per-byte decoder and a
// four-entry result queue in front of the master stream port.
// Depends on bst_pkg and bst_decode.
// A byte accepted on s_ is held in the stage register and then written to the
// result queue, whose head drives m_. Throughput: one byte per cycle while each
// byte makes at most one result and m_tready stays high; the two results of a
// byte leave one after another through the single result port. Synchronous
// active-low reset returns the scan mode to idle and empties the stage and the result queue.
module byte_stream_tokenizer
    import bst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] value, [8] first_char, [9] token_end, zeros above
    output logic [3:0]  m_tuser,   // [3:0] kind
    output logic        m_tlast    // last
);

    localparam int unsigned QDepth = 4;
    localparam int unsigned PtrW   = $clog2(QDepth);

    logic             stage_valid_reg;
    logic             stage_valid_next;
    logic [ByteW-1:0] stage_byte_reg;
    mode_t            mode_reg;
    mode_t            mode_next;
    decode_t          dec;

    result_t          queue_reg [QDepth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PtrW:0]    count_reg, count_next;

    logic             consume;
    logic             pop;
    logic [1:0]       push_n;
    logic [PtrW-1:0]  wr_ptr_plus1;
    result_t          head;

    bst_decode u_decode (
        .ch   (stage_byte_reg),
        .mode (mode_reg),
        .dec  (dec)
    );

    // The staged byte moves on only when the queue has room for two results.
    assign consume  = stage_valid_reg && (count_reg <= (PtrW+1)'(QDepth - 2));
    assign s_tready = !stage_valid_reg || consume;
    assign pop      = m_tvalid && m_tready;
    assign push_n   = consume ? dec.count : 2'd0;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (s_tready) begin
            stage_valid_next = s_tvalid;
        end
        mode_next   = consume ? dec.mode : mode_reg;
        wr_ptr_next = wr_ptr_reg + PtrW'(push_n);
        rd_ptr_next = rd_ptr_reg + PtrW'(pop);
        count_next  = count_reg + (PtrW+1)'(push_n) - (PtrW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            mode_reg        <= MODE_IDLE;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            mode_reg        <= mode_next;
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            count_reg       <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            stage_byte_reg <= s_tdata;
        end
        if (push_n != 2'd0) begin
            queue_reg[wr_ptr_reg] <= dec.res0;
        end
        if (push_n == 2'd2) begin
            queue_reg[wr_ptr_plus1] <= dec.res1;
        end
    end

    assign head     = queue_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {6'b0, head.token_end, head.first_char, head.value};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

endmodule
